// ===== sv/gdcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian date calendar unit package
// Transaction types, stage types, constants and calendar look-up functions
// shared by the pipeline stages.
// ----------------------------------------------------------------------------
package gdcu_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned Q100W  = 7;
  localparam int unsigned Q7W    = 12;

  // Month codes that matter to the control logic.
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [YearW-1:0] YearMax = 14'd9999;

  // Weekday codes.
  localparam logic [2:0] DowFri = 3'd5;
  localparam logic [2:0] DowSat = 3'd6;

  // Division by 100 as multiplication by a reciprocal, exact for the year range.
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  // Division by 7, exact for sums below 2**15.
  localparam logic [14:0] Div7Mul     = 15'd18725;
  localparam int unsigned Div7Shift   = 17;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } in_t;

  typedef struct packed {
    logic              date_valid;
    logic [2:0]        day_of_week;
    logic              is_end_of_week;
    logic              is_weekend;
    logic              is_work_day;
    logic [2:0]        days_to_end_of_week;
    logic [DayW-1:0]   days_to_end_of_month;
    logic [DoyW-1:0]   days_to_end_of_year;
    logic [YearW-1:0]  next_year;
    logic [MonthW-1:0] next_month;
    logic [DayW-1:0]   next_day;
  } out_t;

  // After the first stage: the date plus the century quotients.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  yy;
    logic [Q100W-1:0]  q_y;
    logic [Q100W-1:0]  q_yy;
  } s1_t;

  // After the second stage: weekday congruence sum and all month/year facts.
  typedef struct packed {
    logic              date_valid;
    logic [YearW-1:0]  dow_sum;
    logic [DayW-1:0]   to_month;
    logic [DoyW-1:0]   to_year;
    logic [YearW-1:0]  next_year;
    logic [MonthW-1:0] next_month;
    logic [DayW-1:0]   next_day;
  } s2_t;

  // After the third stage: all second-stage fields and the sum's quotient by seven.
  typedef struct packed {
    s2_t             cal;
    logic [Q7W-1:0]  q7;
  } s3_t;

  // Month length for the given leap flag; zero for codes that name no month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = '0;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
      4'd2:                                         len = leap ? 5'd29 : 5'd28;
      default:                                      len = '0;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 with mm the March-based month number.
  function automatic logic [DayW-1:0] month_shift(input logic [MonthW-1:0] m);
    logic [DayW-1:0] v;
    v = '0;
    case (m)
      4'd1:    v = 5'd28;
      4'd2:    v = 5'd31;
      4'd3:    v = 5'd2;
      4'd4:    v = 5'd5;
      4'd5:    v = 5'd7;
      4'd6:    v = 5'd10;
      4'd7:    v = 5'd12;
      4'd8:    v = 5'd15;
      4'd9:    v = 5'd18;
      4'd10:   v = 5'd20;
      4'd11:   v = 5'd23;
      4'd12:   v = 5'd25;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Days in the months before this one, common year.
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] v;
    v = '0;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/gdcu_century.sv =====
// ----------------------------------------------------------------------------
// Century quotient stage
// Shifts the year for January and February and divides both the year and
// the shifted year by 100 through reciprocal multiplication.
// ----------------------------------------------------------------------------
module gdcu_century (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  gdcu_pkg::in_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output gdcu_pkg::s1_t data_o
);
  import gdcu_pkg::*;

  localparam int unsigned ProdW = YearW + 13;

  logic              valid_q;
  s1_t               data_d, data_q;
  logic              early;
  logic [ProdW-1:0]  prod_y, prod_yy;

  always_comb begin
    early          = (data_i.month == MonthJan) || (data_i.month == MonthFeb);
    data_d.year    = data_i.year;
    data_d.month   = data_i.month;
    data_d.day     = data_i.day;
    data_d.yy      = data_i.year - YearW'(early);
    prod_y         = ProdW'(data_i.year) * ProdW'(Div100Mul);
    prod_yy        = ProdW'(data_d.yy) * ProdW'(Div100Mul);
    data_d.q_y     = prod_y[Div100Shift +: Q100W];
    data_d.q_yy    = prod_yy[Div100Shift +: Q100W];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/gdcu_calendar.sv =====
// ----------------------------------------------------------------------------
// Calendar stage
// Leap year, month length, validity, weekday congruence sum, days left in
// the month and the year, and the following date.
// ----------------------------------------------------------------------------
module gdcu_calendar (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  gdcu_pkg::s1_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output gdcu_pkg::s2_t data_o
);
  import gdcu_pkg::*;

  logic             valid_q;
  s2_t              data_d, data_q;
  logic             cent, leap, last_day, late_leap;
  logic [DayW-1:0]  len;
  logic [YearW-1:0] y100;
  logic [DoyW-1:0]  doy, year_len;

  always_comb begin
    y100      = YearW'(data_i.q_y) * YearW'(100);
    cent      = (y100 == data_i.year);
    // Divisible by 400 is a whole century whose century count divides by 4.
    leap      = ((data_i.year[1:0] == 2'b00) && !cent) ||
                (cent && (data_i.q_y[1:0] == 2'b00));
    len       = month_len(data_i.month, leap);
    last_day  = (data_i.day == len);

    data_d.date_valid = (data_i.year != '0) && (data_i.year <= YearMax) &&
                        (len != '0) && (data_i.day != '0) && (data_i.day <= len);

    data_d.dow_sum = YearW'(data_i.day) + data_i.yy + (data_i.yy >> 2)
                   - YearW'(data_i.q_yy) + YearW'(data_i.q_yy >> 2)
                   + YearW'(month_shift(data_i.month));

    data_d.to_month = len - data_i.day + DayW'(1);

    late_leap = leap && (data_i.month > MonthFeb);
    doy       = days_before(data_i.month) + DoyW'(late_leap) + DoyW'(data_i.day);
    year_len  = DoyW'(365) + DoyW'(leap);
    data_d.to_year = year_len - doy + DoyW'(1);

    if (last_day && (data_i.month == MonthDec)) begin
      data_d.next_year  = data_i.year + YearW'(1);
      data_d.next_month = MonthJan;
      data_d.next_day   = DayW'(1);
    end else if (last_day) begin
      data_d.next_year  = data_i.year;
      data_d.next_month = data_i.month + MonthW'(1);
      data_d.next_day   = DayW'(1);
    end else begin
      data_d.next_year  = data_i.year;
      data_d.next_month = data_i.month;
      data_d.next_day   = data_i.day + DayW'(1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/gdcu_weekday.sv =====
// ----------------------------------------------------------------------------
// Weekday stages
// Divides the congruence sum by seven in one stage, then forms the remainder,
// the weekday flags and the masked result in the output register.
// ----------------------------------------------------------------------------
module gdcu_weekday (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  gdcu_pkg::s2_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output gdcu_pkg::out_t data_o
);
  import gdcu_pkg::*;

  localparam int unsigned ProdW = YearW + 15;

  logic             s3_valid_q, s4_valid_q;
  logic             s3_ready, s4_ready;
  s3_t              s3_d, s3_q;
  out_t             s4_d, s4_q;
  logic [ProdW-1:0] prod;
  logic [YearW:0]   rem;
  logic [2:0]       dow;
  logic             wkend;

  // Quotient by seven.
  always_comb begin
    prod      = ProdW'(data_i.dow_sum) * ProdW'(Div7Mul);
    s3_d.cal  = data_i;
    s3_d.q7   = prod[Div7Shift +: Q7W];
  end

  // Remainder and result fields; an invalid date gives an all-zero result.
  always_comb begin
    rem   = (YearW+1)'(s3_q.cal.dow_sum) - (YearW+1)'(s3_q.q7) * (YearW+1)'(7);
    dow   = rem[2:0];
    wkend = (dow == DowFri) || (dow == DowSat);
    s4_d  = '0;
    if (s3_q.cal.date_valid) begin
      s4_d.date_valid           = 1'b1;
      s4_d.day_of_week          = dow;
      s4_d.is_end_of_week       = (dow == DowSat);
      s4_d.is_weekend           = wkend;
      s4_d.is_work_day          = !wkend;
      s4_d.days_to_end_of_week  = DowSat - dow;
      s4_d.days_to_end_of_month = s3_q.cal.to_month;
      s4_d.days_to_end_of_year  = s3_q.cal.to_year;
      s4_d.next_year            = s3_q.cal.next_year;
      s4_d.next_month           = s3_q.cal.next_month;
      s4_d.next_day             = s3_q.cal.next_day;
    end
  end

  assign s4_ready = !s4_valid_q || ready_i;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign ready_o  = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s3_ready) begin
      s3_q <= s3_d;
    end
    if (s3_valid_q && s4_ready) begin
      s4_q <= s4_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign data_o  = s4_q;

endmodule

// ===== sv/gregorian_date_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// Gregorian date calendar unit
// Gives the weekday facts, the days left in the week, month and year, and
// the following date for one proleptic Gregorian date per transaction.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                   | Payload
//   --------+-----------+-----------------------------+---------------------
//   in      | input     | in_valid_i  / in_ready_o    | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_ready_i   | out_data_o (out_t)
//
// Each transaction passes through four register stages: century quotients,
// calendar facts, division by seven and the output register. The first stage
// is loaded at the accepting edge, and the result is held in the output
// register until it is taken. One transaction can be accepted every cycle
// unless a stall at the output has backed up to the input. Reset clears only
// the stage valid bits. A stall at the output fills the empty stages first;
// a stage holds its contents while the stage after it is full and not moving,
// so nothing is dropped or repeated.
//
module gregorian_date_calendar_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gdcu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gdcu_pkg::out_t out_data_o
);
  import gdcu_pkg::*;

  // Handshakes between the stages.  Each stage is ready whenever its own
  // register is empty or is being emptied in the same cycle.
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  s1_t  s1_data;
  s2_t  s2_data;

  // Stage one: year shifted for January and February, and both years
  // divided by 100 by reciprocal multiplication.
  gdcu_century u_century (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage two: leap year, validity, month length, the weekday congruence sum
  // and the rollover to the following date.
  gdcu_calendar u_calendar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stages three and four: quotient by seven, then the remainder, the flags
  // and the output register, which zeroes every field of an invalid date.
  gdcu_weekday u_weekday (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== bench/gregorian_date_calendar_unit_test.sv =====
// ----------------------------------------------------------------------------
// Gregorian date calendar unit testbench
// Drives dates into the calendar unit through its input channel and checks
// every result against a calendar predictor of its own. The run has a
// directed part followed by random phases with different idling on each
// side, and one long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module gregorian_date_calendar_unit_test;

  import gdcu_pkg::*;

  // Per-phase transaction counts; four random phases give 1864 dates
  // together with the directed part.
  localparam int unsigned PhaseDates = 460;
  // The run is stopped as failed if it takes longer than this many cycles.
  localparam int unsigned CycleLimit = 200000;
  // Length of the long output hold-off, in cycles.
  localparam int unsigned HoldCycles = 120;
  // Cycles allowed after the last expected result for stray results to show.
  localparam int unsigned DrainCycles = 12;
  // Width of one input transaction, for raw random stimulus.
  localparam int unsigned DateBits = $bits(in_t);

  // Holds the calendar facts expected for every accepted date, in order, and
  // compares each result from the block with the oldest of them.
  class date_scoreboard;
    out_t        expected_facts[$];
    int unsigned mismatches    = 0;
    int unsigned checked       = 0;
    int unsigned valid_dates   = 0;
    int unsigned invalid_dates = 0;
    int unsigned year_rolls    = 0;

    function automatic bit leap(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
        4, 6, 9, 11: return 30;
        2:           return leap(y) ? 29 : 28;
        default:     return 31;
      endcase
    endfunction

    // The calendar facts of one date, all zero when the date is not a real one.
    function automatic out_t calendar_facts(in_t d);
      out_t        r;
      int unsigned y, m, dd, len, yy, mm, dow, left_in_year, k;
      r  = '0;
      y  = d.year;
      m  = d.month;
      dd = d.day;
      if (y < 1 || y > 9999 || m < 1 || m > 12 || dd < 1) return r;
      len = month_length(y, m);
      if (dd > len) return r;

      // Weekday by the congruence with the year starting in March, so that
      // January and February belong to the year before.
      if (m < 3) begin
        yy = y - 1;
        mm = m + 10;
      end else begin
        yy = y;
        mm = m - 2;
      end
      dow = (dd + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;

      left_in_year = len - dd + 1;
      for (k = m + 1; k <= 12; k++) left_in_year += month_length(y, k);

      r.date_valid           = 1'b1;
      r.day_of_week          = dow[2:0];
      r.is_end_of_week       = (dow == 6);
      r.is_weekend           = (dow == 5 || dow == 6);
      r.is_work_day          = !(dow == 5 || dow == 6);
      r.days_to_end_of_week  = 3'(6 - dow);
      r.days_to_end_of_month = 5'(len - dd + 1);
      r.days_to_end_of_year  = 9'(left_in_year);
      if (dd == len) begin
        r.next_year  = (m == 12) ? 14'(y + 1) : 14'(y);
        r.next_month = (m == 12) ? 4'd1 : 4'(m + 1);
        r.next_day   = 5'd1;
      end else begin
        r.next_year  = 14'(y);
        r.next_month = 4'(m);
        r.next_day   = 5'(dd + 1);
      end
      return r;
    endfunction

    function void note_date(in_t d);
      out_t want;
      want = calendar_facts(d);
      expected_facts.push_back(want);
      if (want.date_valid) begin
        valid_dates++;
        if (want.next_year != d.year) year_rolls++;
      end else begin
        invalid_dates++;
      end
    endfunction

    function void field_check(string field, logic [13:0] want, logic [13:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_facts.size() == 0) begin
        $display("%0t: result with no date outstanding, expected nothing, got %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_facts.pop_front();
      checked++;
      field_check("date_valid", want.date_valid, got.date_valid);
      field_check("day_of_week", want.day_of_week, got.day_of_week);
      field_check("is_end_of_week", want.is_end_of_week, got.is_end_of_week);
      field_check("is_weekend", want.is_weekend, got.is_weekend);
      field_check("is_work_day", want.is_work_day, got.is_work_day);
      field_check("days_to_end_of_week", want.days_to_end_of_week,
                  got.days_to_end_of_week);
      field_check("days_to_end_of_month", want.days_to_end_of_month,
                  got.days_to_end_of_month);
      field_check("days_to_end_of_year", want.days_to_end_of_year,
                  got.days_to_end_of_year);
      field_check("next_year", want.next_year, got.next_year);
      field_check("next_month", want.next_month, got.next_month);
      field_check("next_day", want.next_day, got.next_day);
    endfunction

    function int unsigned outstanding();
      return expected_facts.size();
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;

  date_scoreboard board;

  // Idling percentages for the current phase, read by the sender task and
  // by the receiver process.
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  // Set by the stimulus to ask the receiver for one long hold-off; the
  // receiver clears it when it starts counting.
  bit          hold_request    = 1'b0;
  int unsigned hold_left       = 0;
  int unsigned cycle_count     = 0;

  gregorian_date_calendar_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a correct run ends long before this count is reached.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, board.outstanding());
      $display("gregorian_date_calendar_unit test failed");
      $finish;
    end
  end

  // Receiver. Ready is redrawn every cycle from the current stall rate, except
  // during the long hold-off, which this process counts down by itself.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Output monitor. Values are sampled at the edge, before the block's
  // registers update, so the order of processes within the step is irrelevant.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  function automatic in_t make_date(int unsigned y, int unsigned m, int unsigned d);
    in_t r;
    r.year  = 14'(y);
    r.month = 4'(m);
    r.day   = 5'(d);
    return r;
  endfunction

  // Random dates. Most are real dates with random content, since those reach
  // the weekday and rollover logic; a share sits on month and year ends and on
  // February in the leap-rule years, some have day zero or a day past the end
  // of the month, and raw bit noise covers every input bit and malformed codes.
  function automatic in_t random_date();
    int unsigned pick, y, m, d;
    pick = $urandom_range(0, 99);
    y    = $urandom_range(1, 9999);
    m    = $urandom_range(1, 12);
    if (pick < 65) begin
      d = $urandom_range(1, board.month_length(y, m));
    end else if (pick < 77) begin
      if ($urandom_range(0, 3) == 0) m = 12;
      if ($urandom_range(0, 9) == 0) y = 9999;
      d = board.month_length(y, m);
    end else if (pick < 87) begin
      case ($urandom_range(0, 2))
        0:       y = 400 * $urandom_range(1, 24);
        1:       y = 100 * $urandom_range(1, 99);
        default: y = 4 * $urandom_range(1, 2499);
      endcase
      m = 2;
      d = $urandom_range(27, 30);
    end else if (pick < 92) begin
      // Day one past the month's end, or day zero.
      d = ($urandom_range(0, 1) == 0) ? board.month_length(y, m) + 1 : 0;
    end else begin
      return in_t'(DateBits'($urandom));
    end
    return make_date(y, m, d);
  endfunction

  // Offers one date and returns once it has been accepted. Valid only drops
  // when the sender chooses to idle, so back-to-back transactions keep it high.
  task automatic send_date(in_t d);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_date(d);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, bit with_hold);
    int unsigned n;
    sender_idle_pct = src_pct;
    sink_stall_pct  = snk_pct;
    for (n = 0; n < PhaseDates; n++) begin
      // Mid-phase the receiver holds off while the sender keeps offering,
      // so the pipeline fills and the input has to stall.
      if (with_hold && n == PhaseDates / 3) hold_request = 1'b1;
      send_date(random_date());
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed dates with no idling: range limits, leap-rule years, month
    // and year rollovers, a full week of weekdays and the malformed codes.
    sink_stall_pct = 0;
    send_date(make_date(1, 1, 1));
    send_date(make_date(9999, 12, 31));
    send_date(make_date(2000, 2, 29));
    send_date(make_date(1900, 2, 29));
    send_date(make_date(1600, 2, 29));
    send_date(make_date(2100, 2, 28));
    send_date(make_date(2024, 2, 28));
    send_date(make_date(2024, 1, 1));
    send_date(make_date(2023, 1, 1));
    send_date(make_date(2024, 12, 31));
    send_date(make_date(2024, 4, 30));
    send_date(make_date(2024, 4, 31));
    send_date(make_date(1970, 1, 1));
    send_date(make_date(2024, 3, 8));
    send_date(make_date(2024, 3, 9));
    send_date(make_date(2024, 3, 10));
    send_date(make_date(2024, 3, 11));
    send_date(make_date(2024, 0, 10));
    send_date(make_date(2024, 13, 1));
    send_date(make_date(2024, 6, 0));
    send_date(make_date(0, 6, 15));
    send_date(make_date(10000, 1, 1));
    send_date(make_date(16383, 15, 31));
    send_date(make_date(0, 0, 0));

    run_phase(0, 0, 1'b1);
    run_phase(70, 0, 1'b0);
    run_phase(0, 70, 1'b0);
    run_phase(11, 11, 1'b0);

    in_valid_i     <= 1'b0;
    sink_stall_pct  = 0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results: %0d real dates, %0d rejected, %0d year rollovers.",
             board.checked, board.valid_dates, board.invalid_dates, board.year_rolls);
    $display("Idling covered none, sender only, receiver only and both, plus one long stall.");
    if (board.mismatches == 0) begin
      $display("gregorian_date_calendar_unit test passed");
    end else begin
      $display("%0d mismatches found.", board.mismatches);
      $display("gregorian_date_calendar_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gdcu_pkg.sv
sv/gdcu_century.sv
sv/gdcu_calendar.sv
sv/gdcu_weekday.sv
sv/gregorian_date_calendar_unit.sv
bench/gregorian_date_calendar_unit_test.sv
